// ----- hw/rtl/rse_pkg.sv -----
// rse_pkg: shared constants, codes and controller/datapath interface types
// for the RPN stack evaluator. No dependencies.
package rse_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int FRAC_BITS   = 32;

    localparam int DATA_W   = 64;
    localparam int HALF_W   = DATA_W / 2;
    localparam int ACC_W    = 2 * DATA_W;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 7;

    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int NUM_W  = DATA_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    localparam int S_TDATA_W = DATA_W;
    localparam int M_TDATA_W = ((DATA_W + STATUS_W + DEPTH_W + 7) / 8) * 8;

    // token kinds; the two remaining codes are unrecognized tokens
    localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SUB    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_MUL    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DIV    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_FINISH = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_TOKEN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic                load;     // capture accepted item
        logic                push;
        logic                set_err;
        logic [STATUS_W-1:0] err_code;
        logic                start;    // second operand ready, init units
        logic                step;     // advance arithmetic unit
        logic                commit;   // replace two operands by the result
        logic                emit;     // load output register
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             err_pending;
        logic             sp_full;
        logic             sp_lt2;
        logic             tos_zero;
        logic             unit_done;
        logic             out_free;
    } dp_stat_t;

endpackage

// ----- hw/rtl/rse_ram.sv -----
// rse_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rse_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/rse_datapath.sv -----
// rse_datapath: top-of-stack register, stack pointer, sticky error, add/sub,
// shared multiply/divide unit and output register. Uses rse_pkg, rse_ram.
module rse_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rse_pkg::dp_cmd_t                cmd,
    output rse_pkg::dp_stat_t               stat,
    input  logic [rse_pkg::REQ_W-1:0]       in_req,
    input  logic [rse_pkg::DATA_W-1:0]      in_value,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [rse_pkg::DATA_W-1:0]      out_top,
    output logic [rse_pkg::STATUS_W-1:0]    out_status,
    output logic [rse_pkg::DEPTH_W-1:0]     out_depth,
    output logic                            out_final
);
    import rse_pkg::*;

    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
        return x[DATA_W-1] ? (DATA_W'(0) - x) : x;
    endfunction

    // item and stack state
    logic [REQ_W-1:0]    req_reg;
    logic [DATA_W-1:0]   val_reg;
    logic [DATA_W-1:0]   tos_reg;
    logic [SP_W-1:0]     sp_reg;
    logic [STATUS_W-1:0] err_reg;

    // arithmetic unit
    logic [DATA_W-1:0]   lhs_reg;
    logic [DATA_W-1:0]   ma_reg;
    logic [DATA_W-1:0]   mb_reg;
    logic                neg_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DATA_W-1:0]   prod_reg;
    logic [1:0]          prod_k_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [DATA_W-1:0]   rem_reg;
    logic [DATA_W-1:0]   q_reg;
    logic                qovf_reg;

    // output register
    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_top_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [DEPTH_W-1:0]  out_depth_reg;
    logic                out_final_reg;

    logic [DATA_W-1:0]   ram_rdata;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [SP_W-1:0]     sp_m1;
    logic [SP_W-1:0]     sp_m2;

    logic                sp_empty;
    logic                out_free;

    assign sp_m1     = sp_reg - SP_W'(1);
    assign sp_m2     = sp_reg - SP_W'(2);
    assign ram_waddr = sp_m1[ADDR_W-1:0];
    assign ram_raddr = sp_m2[ADDR_W-1:0];
    assign ram_we    = cmd.push && !sp_empty;

    // entries below the top live in the RAM at their own index
    rse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (tos_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sp_empty = (sp_reg == '0);
    assign out_free = !out_valid_reg || out_ready;

    // ---- add / subtract with saturation
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] add_res;
    logic [DATA_W-1:0] sub_res;

    always_comb begin
        sum     = lhs_reg + tos_reg;
        diff    = lhs_reg - tos_reg;
        add_res = sum;
        sub_res = diff;
        if ((lhs_reg[DATA_W-1] == tos_reg[DATA_W-1]) &&
            (sum[DATA_W-1] != lhs_reg[DATA_W-1])) begin
            add_res = lhs_reg[DATA_W-1] ? SAT_MIN : SAT_MAX;
        end
        if ((lhs_reg[DATA_W-1] != tos_reg[DATA_W-1]) &&
            (diff[DATA_W-1] != lhs_reg[DATA_W-1])) begin
            sub_res = lhs_reg[DATA_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    // ---- multiply: four 32x32 partial products, then sign, shift, saturate
    logic [HALF_W-1:0] a_half;
    logic [HALF_W-1:0] b_half;
    logic [DATA_W-1:0] partial;
    logic [ACC_W-1:0]  prod_shifted;
    logic [ACC_W-1:0]  acc_sh;
    logic [DATA_W-1:0] mul_res;

    assign a_half  = cnt_reg[1] ? ma_reg[DATA_W-1:HALF_W] : ma_reg[HALF_W-1:0];
    assign b_half  = cnt_reg[0] ? mb_reg[DATA_W-1:HALF_W] : mb_reg[HALF_W-1:0];
    assign partial = a_half * b_half;

    always_comb begin
        unique case (prod_k_reg)
            2'd0:    prod_shifted = ACC_W'(prod_reg);
            2'd3:    prod_shifted = ACC_W'(prod_reg) << DATA_W;
            default: prod_shifted = ACC_W'(prod_reg) << HALF_W;
        endcase
    end

    assign acc_sh = ACC_W'($signed(acc_reg) >>> FRAC_BITS);

    always_comb begin
        if (acc_sh[ACC_W-1:DATA_W] != {DATA_W{acc_sh[DATA_W-1]}}) begin
            mul_res = acc_sh[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            mul_res = acc_sh[DATA_W-1:0];
        end
    end

    // ---- divide: restoring, one quotient bit per cycle
    logic [DATA_W:0]   rem_sh;
    logic              rem_ge;
    logic [DATA_W:0]   rem_sub;
    logic [DATA_W-1:0] div_res;

    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, mb_reg});
    assign rem_sub = rem_sh - {1'b0, mb_reg};

    always_comb begin
        if (neg_reg) begin
            if (qovf_reg || (q_reg > SAT_MIN)) begin
                div_res = SAT_MIN;
            end else begin
                div_res = DATA_W'(0) - q_reg;
            end
        end else begin
            if (qovf_reg || (q_reg > SAT_MAX)) begin
                div_res = SAT_MAX;
            end else begin
                div_res = q_reg;
            end
        end
    end

    logic [DATA_W-1:0] arith_res;
    logic              unit_done;

    always_comb begin
        unique case (req_reg)
            REQ_ADD: begin
                arith_res = add_res;
                unit_done = 1'b1;
            end
            REQ_SUB: begin
                arith_res = sub_res;
                unit_done = 1'b1;
            end
            REQ_MUL: begin
                arith_res = mul_res;
                unit_done = (cnt_reg == CNT_W'(6));
            end
            REQ_DIV: begin
                arith_res = div_res;
                unit_done = (cnt_reg == CNT_W'(NUM_W));
            end
            default: begin
                arith_res = add_res;
                unit_done = 1'b0;
            end
        endcase
    end

    // ---- status to the controller
    always_comb begin
        stat.req         = req_reg;
        stat.err_pending = (err_reg != ST_OK);
        stat.sp_full     = (sp_reg == SP_W'(STACK_DEPTH));
        stat.sp_lt2      = (sp_reg < SP_W'(2));
        stat.tos_zero    = (tos_reg == '0);
        stat.unit_done   = unit_done;
        stat.out_free    = out_free;
    end

    // ---- arithmetic unit registers (payload, no reset)
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= in_req;
            val_reg <= in_value;
        end
        if (cmd.start) begin
            lhs_reg  <= ram_rdata;
            ma_reg   <= mag(ram_rdata);
            mb_reg   <= mag(tos_reg);
            neg_reg  <= ram_rdata[DATA_W-1] ^ tos_reg[DATA_W-1];
            cnt_reg  <= '0;
            acc_reg  <= '0;
            num_reg  <= NUM_W'(mag(ram_rdata)) << FRAC_BITS;
            rem_reg  <= '0;
            q_reg    <= '0;
            qovf_reg <= 1'b0;
        end else if (cmd.step) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (req_reg == REQ_MUL) begin
                if (cnt_reg < CNT_W'(4)) begin
                    prod_reg   <= partial;
                    prod_k_reg <= cnt_reg[1:0];
                end
                if ((cnt_reg >= CNT_W'(1)) && (cnt_reg <= CNT_W'(4))) begin
                    acc_reg <= acc_reg + prod_shifted;
                end else if (cnt_reg == CNT_W'(5)) begin
                    acc_reg <= neg_reg ? (ACC_W'(0) - acc_reg) : acc_reg;
                end
            end
            if ((req_reg == REQ_DIV) && (cnt_reg < CNT_W'(NUM_W))) begin
                num_reg  <= num_reg << 1;
                rem_reg  <= rem_ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                q_reg    <= {q_reg[DATA_W-2:0], rem_ge};
                qovf_reg <= qovf_reg | q_reg[DATA_W-1];
            end
        end
    end

    // ---- top of stack and output payload
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            tos_reg <= val_reg;
        end else if (cmd.commit) begin
            tos_reg <= arith_res;
        end
        if (cmd.emit && out_free) begin
            if (req_reg == REQ_FINISH) begin
                out_top_reg    <= (stat.err_pending || sp_empty) ? '0 : tos_reg;
                out_status_reg <= stat.err_pending ? err_reg :
                                  (sp_empty ? ST_UNDERFLOW : ST_OK);
                out_depth_reg  <= '0;
                out_final_reg  <= 1'b1;
            end else begin
                out_top_reg    <= sp_empty ? '0 : tos_reg;
                out_status_reg <= err_reg;
                out_depth_reg  <= DEPTH_W'(sp_reg);
                out_final_reg  <= 1'b0;
            end
        end
    end

    // ---- control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg        <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.push) begin
                sp_reg <= sp_reg + SP_W'(1);
            end else if (cmd.commit) begin
                sp_reg <= sp_m1;
            end
            if (cmd.set_err) begin
                err_reg <= cmd.err_code;
            end
            if (cmd.emit && out_free) begin
                out_valid_reg <= 1'b1;
                if (req_reg == REQ_FINISH) begin
                    sp_reg  <= '0;
                    err_reg <= ST_OK;
                end
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_top    = out_top_reg;
    assign out_status = out_status_reg;
    assign out_depth  = out_depth_reg;
    assign out_final  = out_final_reg;

endmodule

// ----- hw/rtl/rse_ctrl.sv -----
// rse_ctrl: one-hot sequencer that decodes a token and drives the datapath.
// Uses rse_pkg.
module rse_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    output rse_pkg::dp_cmd_t  cmd,
    input  rse_pkg::dp_stat_t stat
);
    import rse_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_READ   = 5'b00100,
        ST_CALC   = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_EMIT;
                priority if (stat.req == REQ_FINISH) begin
                    // result and clearing done at emit
                end else if (stat.err_pending) begin
                    // ignored while an error is pending
                end else if (stat.req == REQ_PUSH) begin
                    if (stat.sp_full) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_OVERFLOW;
                    end else begin
                        cmd.push = 1'b1;
                    end
                end else if ((stat.req == REQ_ADD) || (stat.req == REQ_SUB) ||
                             (stat.req == REQ_MUL) || (stat.req == REQ_DIV)) begin
                    if (stat.sp_lt2) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_UNDERFLOW;
                    end else if ((stat.req == REQ_DIV) && stat.tos_zero) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_DIV_ZERO;
                    end else begin
                        state_next = ST_READ;
                    end
                end else begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ST_BAD_TOKEN;
                end
            end
            ST_READ: begin
                cmd.start  = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                if (stat.unit_done) begin
                    cmd.commit = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_EMIT: begin
                cmd.emit = 1'b1;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/rpn_stack_evaluator_top.sv -----
// rpn_stack_evaluator_top: reverse Polish evaluator on signed Q32.32 values.
// Uses rse_pkg, rse_ctrl, rse_datapath (which holds rse_ram).
//
// Usage:
//   Input stream (s_): one token per item; s_tuser is the token kind
//   (push, add, sub, mul, div, finish; other codes are bad tokens), s_tdata
//   the number to push. Output stream (m_): exactly one item per input
//   item, carrying the top of stack (or the popped result on finish), the
//   status code and the stack depth; m_tlast marks the answer to a finish.
// Timing:
//   One token at a time. Push, finish, ignored and error tokens go from accept
//   through decode to emit; add, sub, multiply and divide also read the operand
//   below the top and calculate. Multiply forms four 32x32 partial products through
//   one multiplier, then signs and saturates; divide is a restoring divider, one
//   quotient bit per cycle. s_tready returns in the same cycle as the result appears.
// Stall: the result sits in an output register, so the next token is taken
//   and worked on while m_tready is low; the block holds in its emit step
//   only when a second result is ready before the first is taken.
// Reset: aresetn (sync, active low) empties the stack, clears any pending
//   error and drops m_tvalid. Stack memory contents are not cleared.
module rpn_stack_evaluator_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rse_pkg::S_TDATA_W-1:0] s_tdata,  // [63:0] operand_value
    input  logic [rse_pkg::REQ_W-1:0]     s_tuser,  // [2:0] req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rse_pkg::M_TDATA_W-1:0] m_tdata,  // [63:0] top_value,
                                                    // [66:64] status,
                                                    // [73:67] stack_depth, rest 0
    output logic                          m_tlast   // is_final
);
    import rse_pkg::*;

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [DATA_W-1:0]   out_top;
    logic [STATUS_W-1:0] out_status;
    logic [DEPTH_W-1:0]  out_depth;

    rse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rse_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_req     (s_tuser),
        .in_value   (s_tdata),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_top    (out_top),
        .out_status (out_status),
        .out_depth  (out_depth),
        .out_final  (m_tlast)
    );

    // pack result fields, lowest first, zero-filled to whole bytes
    assign m_tdata = M_TDATA_W'({out_depth, out_status, out_top});

endmodule

// ----- bench/rpn_stack_evaluator_tb.sv -----
// Self-checking bench for rpn_stack_evaluator_top: token streams against a local Q32.32 stack model.
// Depends on rse_pkg and the evaluator RTL; needs no files or arguments.
module tb;
    import rse_pkg::*;

    // codes 6 and 7 carry no meaning in the package; both must be flagged
    localparam logic [REQ_W-1:0] REQ_BAD_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_BAD_HI = 3'd7;

    // a few Q32.32 constants
    localparam logic [DATA_W-1:0] ONE_Q     = 64'h0000_0001_0000_0000;
    localparam logic [DATA_W-1:0] NEG_ONE_Q = 64'hFFFF_FFFF_0000_0000;
    localparam logic [DATA_W-1:0] HALF_Q    = 64'h0000_0000_8000_0000;
    localparam logic [DATA_W-1:0] TWO_Q     = 64'h0000_0002_0000_0000;
    localparam logic [DATA_W-1:0] THREE_Q   = 64'h0000_0003_0000_0000;

    // slowest token is a divide; leave margin
    localparam int DRAIN_CYCLES   = 64 + FRAC_BITS + 40;
    localparam int TIMEOUT_CYCLES = 900_000;

    typedef struct {
        logic [DATA_W-1:0]   top;
        logic [STATUS_W-1:0] status;
        logic [DEPTH_W-1:0]  depth;
        logic                fin;
    } answer_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [REQ_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // local copy of the evaluator state
    logic [DATA_W-1:0]   calc_stack [STACK_DEPTH];
    int                  calc_depth = 0;
    logic [STATUS_W-1:0] calc_err   = ST_OK;

    answer_t expected_answers[$];
    int      fail_count     = 0;
    int      live_tokens    = 0;   // tokens that were not ignored by a pending error
    int      send_idle_pct  = 0;
    int      sink_stall_pct = 0;

    rpn_stack_evaluator_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [63:0] operand_value
        .s_tuser  (s_tuser),   // [2:0] req_type
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [63:0] top_value, [66:64] status, [73:67] stack_depth
        .m_tlast  (m_tlast)    // is_final
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------- arithmetic of the stack model ----------------

    function automatic logic [DATA_W-1:0] add_sat(input logic [DATA_W-1:0] a, b);
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? SAT_MIN : SAT_MAX;
        return s[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] sub_sat(input logic [DATA_W-1:0] a, b);
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? SAT_MIN : SAT_MAX;
        return s[DATA_W-1:0];
    endfunction

    // exact product, floor shift by FRAC_BITS, then clamp
    function automatic logic [DATA_W-1:0] mul_fx(input logic [DATA_W-1:0] a, b);
        logic signed [ACC_W-1:0] p;
        p = $signed({{DATA_W{a[DATA_W-1]}}, a}) * $signed({{DATA_W{b[DATA_W-1]}}, b});
        p = p >>> FRAC_BITS;
        if (p[ACC_W-1:DATA_W-1] != {(DATA_W+1){p[DATA_W-1]}})
            return p[ACC_W-1] ? SAT_MIN : SAT_MAX;
        return p[DATA_W-1:0];
    endfunction

    // magnitudes divided, truncated toward zero, sign applied, clamped
    function automatic logic [DATA_W-1:0] div_fx(input logic [DATA_W-1:0] a, b);
        logic [DATA_W-1:0] ma, mb;
        logic [ACC_W-1:0]  num, q;
        ma  = a[DATA_W-1] ? -a : a;
        mb  = b[DATA_W-1] ? -b : b;
        num = {{DATA_W{1'b0}}, ma} << FRAC_BITS;
        q   = num / {{DATA_W{1'b0}}, mb};
        if (a[DATA_W-1] ^ b[DATA_W-1]) begin
            if (q > {{DATA_W{1'b0}}, SAT_MIN}) return SAT_MIN;
            return -q[DATA_W-1:0];
        end
        if (q > {{DATA_W{1'b0}}, SAT_MAX}) return SAT_MAX;
        return q[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] stack_top();
        return (calc_depth == 0) ? '0 : calc_stack[calc_depth-1];
    endfunction

    // advance the stack model by one token and queue the answer it gives
    task automatic eval_token(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] operand);
        answer_t           ans;
        logic [DATA_W-1:0] lhs, rhs, res;
        if (req == REQ_FINISH) begin
            ans.status = calc_err;
            ans.top    = '0;
            if (calc_err == ST_OK) begin
                if (calc_depth == 0) ans.status = ST_UNDERFLOW;
                else ans.top = stack_top();
            end
            ans.depth  = '0;
            ans.fin    = 1'b1;
            calc_depth = 0;
            calc_err   = ST_OK;
        end else begin
            if (calc_err == ST_OK) begin
                case (req)
                    REQ_PUSH: begin
                        if (calc_depth >= STACK_DEPTH) calc_err = ST_OVERFLOW;
                        else begin
                            calc_stack[calc_depth] = operand;
                            calc_depth++;
                        end
                    end
                    REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
                        if (calc_depth < 2) calc_err = ST_UNDERFLOW;
                        else begin
                            rhs = calc_stack[calc_depth-1];
                            lhs = calc_stack[calc_depth-2];
                            if (req == REQ_DIV && rhs == '0) calc_err = ST_DIV_ZERO;
                            else begin
                                case (req)
                                    REQ_ADD: res = add_sat(lhs, rhs);
                                    REQ_SUB: res = sub_sat(lhs, rhs);
                                    REQ_MUL: res = mul_fx(lhs, rhs);
                                    default: res = div_fx(lhs, rhs);
                                endcase
                                calc_depth--;
                                calc_stack[calc_depth-1] = res;
                            end
                        end
                    end
                    default: calc_err = ST_BAD_TOKEN;
                endcase
            end
            ans.top    = stack_top();
            ans.status = calc_err;
            ans.depth  = DEPTH_W'(calc_depth);
            ans.fin    = 1'b0;
        end
        expected_answers.push_back(ans);
    endtask

    // ---------------- stimulus ----------------

    // mix of extremes, raw 64-bit noise and moderate Q32.32 numbers
    function automatic logic [DATA_W-1:0] pick_operand();
        int unsigned      r;
        logic [HALF_W-1:0] whole;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            case ($urandom_range(0, 6))
                0: return SAT_MAX;
                1: return SAT_MIN;
                2: return '0;
                3: return 64'd1;
                4: return '1;
                5: return ONE_Q;
                default: return NEG_ONE_Q;
            endcase
        end
        if (r < 40) return {$urandom, $urandom};
        whole = HALF_W'(int'($urandom_range(0, 2000)) - 1000);
        return {whole, HALF_W'($urandom)};
    endfunction

    // one item on the input stream; valid stays up on return so back-to-back
    // items never drop and raise it in the same step
    task automatic send_token(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] operand);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= operand;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (req == REQ_FINISH || calc_err == ST_OK) live_tokens++;
        eval_token(req, operand);
    endtask

    // always spends at least one edge so the next drive lands in a later step
    task automatic wait_answers_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_answers.size() != 0);
    endtask

    // finish on empty, underflow, divide by zero, bad tokens, ignored items
    task automatic test_error_cases();
        send_token(REQ_FINISH, '0);
        send_token(REQ_PUSH, ONE_Q);
        send_token(REQ_SUB, '0);
        send_token(REQ_PUSH, TWO_Q);        // ignored, underflow pending
        send_token(REQ_FINISH, '0);
        send_token(REQ_PUSH, ONE_Q);
        send_token(REQ_PUSH, '0);
        send_token(REQ_DIV, '0);
        send_token(REQ_FINISH, '0);
        send_token(REQ_BAD_LO, SAT_MAX);
        send_token(REQ_FINISH, '0);
        send_token(REQ_PUSH, ONE_Q);
        send_token(REQ_BAD_HI, '1);
        send_token(REQ_ADD, '0);            // ignored, bad token pending
        send_token(REQ_FINISH, '0);
    endtask

    // every operator clamping: add and divide high, subtract low, multiply at both ends
    task automatic test_saturation();
        send_token(REQ_PUSH, SAT_MAX);
        send_token(REQ_PUSH, 64'd1);
        send_token(REQ_ADD, '0);            // max + ulp
        send_token(REQ_PUSH, SAT_MIN);
        send_token(REQ_PUSH, 64'd1);
        send_token(REQ_SUB, '0);            // min - ulp
        send_token(REQ_MUL, '0);            // max * min
        send_token(REQ_PUSH, NEG_ONE_Q);
        send_token(REQ_MUL, '0);            // min * -1.0 overflows positive
        send_token(REQ_PUSH, 64'd1);
        send_token(REQ_DIV, '0);            // max / ulp
        send_token(REQ_FINISH, '0);
    endtask

    // plain values, rounding of multiply and truncation of divide
    task automatic test_fixed_point();
        send_token(REQ_PUSH, THREE_Q);
        send_token(REQ_PUSH, TWO_Q);
        send_token(REQ_DIV, '0);            // 1.5
        send_token(REQ_PUSH, '1);
        send_token(REQ_PUSH, HALF_Q);
        send_token(REQ_MUL, '0);            // -ulp * 0.5 floors to -ulp
        send_token(REQ_ADD, '0);
        send_token(REQ_PUSH, -THREE_Q);
        send_token(REQ_DIV, '0);            // negative quotient, toward zero
        send_token(REQ_FINISH, '0);
    endtask

    // fill the stack, one push too many, then an ignored operator
    task automatic test_stack_overflow();
        repeat (STACK_DEPTH) send_token(REQ_PUSH, pick_operand());
        send_token(REQ_PUSH, pick_operand());
        send_token(REQ_ADD, '0);
        send_token(REQ_FINISH, '0);
    endtask

    // mostly well-formed expressions with random numbers, some noise and
    // broken ones; a few fill the stack or overflow it
    task automatic test_random_exprs(input int n_tokens);
        int               stop_at, target, pushed;
        int unsigned      r;
        bit               pushes_only;
        logic [REQ_W-1:0] code;
        stop_at = live_tokens + n_tokens;
        while (live_tokens < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 80) target = $urandom_range(1, 8);
            else if (r < 95) target = $urandom_range(9, 40);
            else if (r < 98) target = STACK_DEPTH;
            else target = STACK_DEPTH + 1;
            pushes_only = (target >= STACK_DEPTH);
            pushed = 0;
            while (calc_err == ST_OK && (pushed < target || calc_depth > 1)) begin
                if ($urandom_range(0, 99) < 4) begin
                    case ($urandom_range(0, 2))
                        0: send_token($urandom_range(0, 1) ? REQ_BAD_LO : REQ_BAD_HI,
                                      pick_operand());
                        1: send_token(REQ_W'($urandom_range(REQ_ADD, REQ_DIV)), pick_operand());
                        default: begin
                            send_token(REQ_PUSH, '0);
                            send_token(REQ_DIV, pick_operand());
                        end
                    endcase
                end else if (pushed < target &&
                             (calc_depth < 2 || pushes_only || $urandom_range(0, 1))) begin
                    send_token(REQ_PUSH, pick_operand());
                    pushed++;
                end else begin
                    send_token(REQ_W'($urandom_range(REQ_ADD, REQ_DIV)), pick_operand());
                end
            end
            // a few items that the pending error swallows
            if (calc_err != ST_OK) begin
                repeat ($urandom_range(0, 3)) begin
                    code = REQ_W'($urandom_range(0, 6));
                    if (code >= REQ_FINISH) code = code + REQ_W'(1);
                    send_token(code, pick_operand());
                end
            end
            send_token(REQ_FINISH, pick_operand());
            if ($urandom_range(0, 99) < 3) wait_answers_drained();
        end
    endtask

    // ---------------- result side ----------------

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic check_field(input string field, input logic [DATA_W-1:0] want, got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : check_answers
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = expected_answers.pop_front();
                check_field("top_value", want.top, m_tdata[63:0]);
                check_field("status", DATA_W'(want.status), DATA_W'(m_tdata[66:64]));
                check_field("stack_depth", DATA_W'(want.depth), DATA_W'(m_tdata[73:67]));
                check_field("is_final", DATA_W'(want.fin), DATA_W'(m_tlast));
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        send_idle_pct  = 38;
        sink_stall_pct = 76;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_error_cases();
        test_saturation();
        test_fixed_point();
        test_stack_overflow();
        wait_answers_drained();

        test_random_exprs(160);
        wait_answers_drained();
        send_idle_pct  = 76;
        sink_stall_pct = 38;
        test_random_exprs(160);
        wait_answers_drained();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        test_random_exprs(160);

        wait_answers_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 12);
        $display("%0t: timeout with %0d answers outstanding", $time, expected_answers.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
